// ----- design/rsa_pkg.sv -----
// rsa_pkg: shared types for the rational sum accumulator
// sequencer states and the control/status bundles of the shared arithmetic unit
// no dependencies
`timescale 1ns / 1ps

package rsa_pkg;

  localparam int unsigned MAG_W = 64;

  localparam logic [MAG_W-1:0] MAX_MAG = {1'b0, {(MAG_W-1){1'b1}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD1,
    ST_QDIV,
    ST_LMUL,
    ST_MADIV,
    ST_P1MUL,
    ST_P2MUL,
    ST_COMB,
    ST_GCD2,
    ST_NDIV,
    ST_DDIV,
    ST_SPLIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic go;
    logic mul;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } alu_sts_t;

endpackage

// ----- design/rsa_alu.sv -----
// rsa_alu: shared bit-serial unit, restoring divide or shift-add multiply
// one bit per cycle, 64 steps per operation, then done; multiply flags
// results above 2^63-1; depends on rsa_pkg
`timescale 1ns / 1ps

module rsa_alu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rsa_pkg::alu_ctl_t     ctl,
  input  logic [63:0]           a,
  input  logic [63:0]           b,
  output rsa_pkg::alu_sts_t     sts,
  output logic [63:0]           quo,
  output logic [63:0]           rem
);

  logic        busy_r;
  logic        done_r;
  logic        mul_r;
  logic        ovf_r, ovf_nxt;
  logic [5:0]  cnt_r;
  logic [63:0] opd_r;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;

  logic [63:0] trial;
  logic        ge;
  logic [64:0] sum;

  always_comb begin
    trial = {rem_r[62:0], quo_r[63]};
    ge    = (trial >= opd_r);
    sum   = {1'b0, rem_r[62:0], 1'b0} + {1'b0, (quo_r[63] ? opd_r : 64'd0)};
    if (mul_r) begin
      rem_nxt = sum[63:0];
      quo_nxt = {quo_r[62:0], 1'b0};
      ovf_nxt = ovf_r | sum[64] | sum[63] | rem_r[63];
    end else begin
      rem_nxt = ge ? (trial - opd_r) : trial;
      quo_nxt = {quo_r[62:0], ge};
      ovf_nxt = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd63;
        mul_r  <= ctl.mul;
        ovf_r  <= 1'b0;
        rem_r  <= 64'd0;
        opd_r  <= ctl.mul ? a : b;
        quo_r  <= ctl.mul ? b : a;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        ovf_r <= ovf_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign quo      = quo_r;
  assign rem      = rem_r;

endmodule

// ----- design/rational_sum_accumulator.sv -----
// rational_sum_accumulator: top level, sequencer and sum registers
// drives one shared bit-serial divide/multiply unit through the gcd/lcm steps
// depends on rsa_pkg and rsa_alu
`timescale 1ns / 1ps

// usage:
// in_* beat carries one signed fraction term; in_start_new_sum clears the sum first.
// out_* beat carries the reduced sum, its mixed-number form and an overflow flag.
// one term is in flight at a time: in_ready is high only while the block is idle.
// the shared unit runs one bit-serial divide or multiply at a time.
// a term runs two gcd loops (one divide per euclid step), four divides and three
// multiplies, then one divide for the whole part; an overflow ends the add early
// and skips to that divide.
// the result beat is held, unchanged, until out_ready; no new term is taken
// before it is delivered.
// reset (synchronous, active low) sets the sum to 0/1 and returns to idle.
// a zero term denominator or a result beyond 2^63-1 leaves the sum unchanged and
// raises out_overflow.

module rational_sum_accumulator #(
  parameter int unsigned TERM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_term_numerator,
  input  logic [30:0]        in_term_denominator,
  input  logic               in_start_new_sum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_sum_numerator,
  output logic [62:0]        out_sum_denominator,
  output logic               out_is_negative,
  output logic [62:0]        out_whole_part,
  output logic [62:0]        out_remainder_numerator,
  output logic               out_overflow
);

  rsa_pkg::state_t   state_r, state_nxt;
  rsa_pkg::alu_ctl_t alu_ctl;
  rsa_pkg::alu_sts_t alu_sts;
  logic [63:0]       alu_a, alu_b, alu_quo, alu_rem;

  logic        issued_r;
  logic [63:0] x_r, y_r, g_r, q_r, l_r, ma_r, p1_r, p2_r, rm_r;
  logic        rneg_r;
  logic [63:0] tmag_r;
  logic        tneg_r;
  logic [30:0] td_r;
  logic [63:0] num_r;
  logic [62:0] den_r;
  logic [62:0] whole_r, remn_r;
  logic        ovf_r;

  logic [TERM_WIDTH-1:0] traw, tmag_in;
  logic [63:0] amag;
  logic [63:0] comb_mag;
  logic        comb_neg, comb_ovf;

  assign traw    = in_term_numerator[TERM_WIDTH-1:0];
  assign tmag_in = traw[TERM_WIDTH-1] ? (~traw + 1'b1) : traw;
  assign amag    = num_r[63] ? (~num_r + 64'd1) : num_r;

  // add or subtract the scaled magnitudes
  always_comb begin
    comb_ovf = 1'b0;
    if (num_r[63] == tneg_r) begin
      comb_mag = p1_r + p2_r;
      comb_neg = tneg_r;
      comb_ovf = comb_mag[63];
    end else if (p1_r >= p2_r) begin
      comb_mag = p1_r - p2_r;
      comb_neg = num_r[63];
    end else begin
      comb_mag = p2_r - p1_r;
      comb_neg = tneg_r;
    end
    if (comb_mag == 64'd0) begin
      comb_neg = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_term_denominator == 31'd0) ? rsa_pkg::ST_SPLIT : rsa_pkg::ST_GCD1;
        end
      end
      rsa_pkg::ST_GCD1: begin
        if (!issued_r && y_r == 64'd0) begin
          state_nxt = rsa_pkg::ST_QDIV;
        end
      end
      rsa_pkg::ST_QDIV:  if (alu_sts.done) state_nxt = rsa_pkg::ST_LMUL;
      rsa_pkg::ST_LMUL: begin
        if (alu_sts.done) begin
          state_nxt = alu_sts.ovf ? rsa_pkg::ST_SPLIT : rsa_pkg::ST_MADIV;
        end
      end
      rsa_pkg::ST_MADIV: if (alu_sts.done) state_nxt = rsa_pkg::ST_P1MUL;
      rsa_pkg::ST_P1MUL: begin
        if (alu_sts.done) begin
          state_nxt = alu_sts.ovf ? rsa_pkg::ST_SPLIT : rsa_pkg::ST_P2MUL;
        end
      end
      rsa_pkg::ST_P2MUL: begin
        if (alu_sts.done) begin
          state_nxt = alu_sts.ovf ? rsa_pkg::ST_SPLIT : rsa_pkg::ST_COMB;
        end
      end
      rsa_pkg::ST_COMB: state_nxt = comb_ovf ? rsa_pkg::ST_SPLIT : rsa_pkg::ST_GCD2;
      rsa_pkg::ST_GCD2: begin
        if (!issued_r && y_r == 64'd0) begin
          state_nxt = rsa_pkg::ST_NDIV;
        end
      end
      rsa_pkg::ST_NDIV:  if (alu_sts.done) state_nxt = rsa_pkg::ST_DDIV;
      rsa_pkg::ST_DDIV:  if (alu_sts.done) state_nxt = rsa_pkg::ST_SPLIT;
      rsa_pkg::ST_SPLIT: if (alu_sts.done) state_nxt = rsa_pkg::ST_DONE;
      rsa_pkg::ST_DONE:  if (out_ready) state_nxt = rsa_pkg::ST_IDLE;
      default: state_nxt = rsa_pkg::ST_IDLE;
    endcase
  end

  // outputs and unit operands
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    alu_ctl.go  = 1'b0;
    alu_ctl.mul = 1'b0;
    alu_a       = 64'd0;
    alu_b       = 64'd1;
    case (state_r)
      rsa_pkg::ST_IDLE: in_ready = 1'b1;
      rsa_pkg::ST_GCD1, rsa_pkg::ST_GCD2: begin
        alu_ctl.go = !issued_r && (y_r != 64'd0);
        alu_a      = x_r;
        alu_b      = y_r;
      end
      rsa_pkg::ST_QDIV: begin
        alu_ctl.go = !issued_r;
        alu_a      = {1'b0, den_r};
        alu_b      = g_r;
      end
      rsa_pkg::ST_LMUL: begin
        alu_ctl.go  = !issued_r;
        alu_ctl.mul = 1'b1;
        alu_a       = q_r;
        alu_b       = 64'(td_r);
      end
      rsa_pkg::ST_MADIV: begin
        alu_ctl.go = !issued_r;
        alu_a      = 64'(td_r);
        alu_b      = g_r;
      end
      rsa_pkg::ST_P1MUL: begin
        alu_ctl.go  = !issued_r;
        alu_ctl.mul = 1'b1;
        alu_a       = ma_r;
        alu_b       = amag;
      end
      rsa_pkg::ST_P2MUL: begin
        alu_ctl.go  = !issued_r;
        alu_ctl.mul = 1'b1;
        alu_a       = q_r;
        alu_b       = tmag_r;
      end
      rsa_pkg::ST_NDIV: begin
        alu_ctl.go = !issued_r;
        alu_a      = rm_r;
        alu_b      = g_r;
      end
      rsa_pkg::ST_DDIV: begin
        alu_ctl.go = !issued_r;
        alu_a      = l_r;
        alu_b      = g_r;
      end
      rsa_pkg::ST_SPLIT: begin
        alu_ctl.go = !issued_r;
        alu_a      = amag;
        alu_b      = {1'b0, den_r};
      end
      rsa_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  rsa_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (alu_ctl),
    .a    (alu_a),
    .b    (alu_b),
    .sts  (alu_sts),
    .quo  (alu_quo),
    .rem  (alu_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rsa_pkg::ST_IDLE;
      issued_r <= 1'b0;
      num_r    <= 64'd0;
      den_r    <= 63'd1;
      ovf_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (alu_ctl.go) begin
        issued_r <= 1'b1;
      end else if (alu_sts.done) begin
        issued_r <= 1'b0;
      end
      case (state_r)
        rsa_pkg::ST_IDLE: begin
          if (in_valid) begin
            tmag_r <= 64'(tmag_in);
            tneg_r <= traw[TERM_WIDTH-1];
            td_r   <= in_term_denominator;
            ovf_r  <= (in_term_denominator == 31'd0);
            if (in_start_new_sum) begin
              num_r <= 64'd0;
              den_r <= 63'd1;
              x_r   <= 64'd1;
            end else begin
              x_r <= {1'b0, den_r};
            end
            y_r <= 64'(in_term_denominator);
          end
        end
        rsa_pkg::ST_GCD1, rsa_pkg::ST_GCD2: begin
          if (!issued_r && y_r == 64'd0) begin
            g_r <= x_r;
          end
          if (alu_sts.done) begin
            x_r <= y_r;
            y_r <= alu_rem;
          end
        end
        rsa_pkg::ST_QDIV:  if (alu_sts.done) q_r <= alu_quo;
        rsa_pkg::ST_LMUL: begin
          if (alu_sts.done) begin
            l_r   <= alu_rem;
            ovf_r <= alu_sts.ovf;
          end
        end
        rsa_pkg::ST_MADIV: if (alu_sts.done) ma_r <= alu_quo;
        rsa_pkg::ST_P1MUL: begin
          if (alu_sts.done) begin
            p1_r  <= alu_rem;
            ovf_r <= alu_sts.ovf;
          end
        end
        rsa_pkg::ST_P2MUL: begin
          if (alu_sts.done) begin
            p2_r  <= alu_rem;
            ovf_r <= alu_sts.ovf;
          end
        end
        rsa_pkg::ST_COMB: begin
          ovf_r  <= comb_ovf;
          rm_r   <= comb_mag;
          rneg_r <= comb_neg;
          x_r    <= comb_mag;
          y_r    <= l_r;
        end
        rsa_pkg::ST_NDIV:  if (alu_sts.done) rm_r <= alu_quo;
        rsa_pkg::ST_DDIV: begin
          if (alu_sts.done) begin
            num_r <= rneg_r ? (~rm_r + 64'd1) : rm_r;
            den_r <= alu_quo[62:0];
          end
        end
        rsa_pkg::ST_SPLIT: begin
          if (alu_sts.done) begin
            whole_r <= alu_quo[62:0];
            remn_r  <= alu_rem[62:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_sum_numerator       = num_r;
  assign out_sum_denominator     = den_r;
  assign out_is_negative         = num_r[63];
  assign out_whole_part          = whole_r;
  assign out_remainder_numerator = remn_r;
  assign out_overflow            = ovf_r;

endmodule

// ----- design/rsa_checker.sv -----
// rsa_checker: port-level checks for rational_sum_accumulator, bound to the top level
// depends on rational_sum_accumulator ports only
`timescale 1ns / 1ps

module rsa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] out_sum_numerator,
  input logic [62:0]        out_sum_denominator,
  input logic               out_is_negative
);

  // one term in flight: no new beat while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in_ready while result pending");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sum_numerator)))
    else $error("result beat dropped or changed");

  a_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sum_denominator != 63'd0)) else $error("zero denominator");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_negative == out_sum_numerator[63])) else $error("sign mismatch");

endmodule

bind rational_sum_accumulator rsa_checker u_rsa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_sum_numerator  (out_sum_numerator),
  .out_sum_denominator(out_sum_denominator),
  .out_is_negative    (out_is_negative)
);

// ----- verif/tb.sv -----
// tb: self-checking testbench for rational_sum_accumulator
// predicts the reduced running sum per term and checks every result beat field by field
// depends on the rational_sum_accumulator rtl
`timescale 1ns / 1ps

module tb;

  localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int LONG_HOLD = 20000;
  localparam longint CYCLE_LIMIT = 64'd100_000_000;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               clr;
  } term_t;

  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic               neg;
    logic [62:0]        whole;
    logic [62:0]        rem;
    logic               ovf;
  } sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_term_numerator = '0;
  logic [30:0] in_term_denominator = '0;
  logic in_start_new_sum = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] out_sum_numerator;
  logic [62:0] out_sum_denominator;
  logic out_is_negative;
  logic [62:0] out_whole_part;
  logic [62:0] out_remainder_numerator;
  logic out_overflow;

  rational_sum_accumulator u_top (.*);

  term_t pending_terms[$];
  sum_t expected_sums[$];
  logic [63:0] acc_num = 64'd0;
  logic [63:0] acc_den = 64'd1;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_count = 0;
  longint cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // update the running sum with one term and return the reported sum
  function automatic sum_t add_term(term_t t);
    logic [63:0] tmag, td, amag, ad, g, q, l, ma, mb, p1, p2, rmag;
    logic tneg, aneg, rneg, ovf;
    sum_t s;
    tneg = t.num[31];
    tmag = tneg ? 64'(-{{32{t.num[31]}}, t.num}) : {32'd0, t.num};
    td = {33'd0, t.den};
    ovf = 1'b0;
    rneg = 1'b0;
    rmag = 0;
    if (t.clr) begin
      acc_num = 0;
      acc_den = 1;
    end
    aneg = acc_num[63];
    amag = aneg ? -acc_num : acc_num;
    ad = (acc_den != 0) ? acc_den : 64'd1;
    if (td == 0) begin
      ovf = 1'b1;
    end else begin
      g = gcd64(ad, td);
      q = ad / g;
      if (q > MAG_LIMIT / td) begin
        ovf = 1'b1;
      end else begin
        l = q * td;
        ma = l / ad;
        mb = q;
        if ((amag != 0 && ma > MAG_LIMIT / amag) || (tmag != 0 && mb > MAG_LIMIT / tmag)) begin
          ovf = 1'b1;
        end else begin
          p1 = ma * amag;
          p2 = mb * tmag;
          if (aneg == tneg) begin
            rmag = p1 + p2;
            rneg = aneg;
            if (rmag > MAG_LIMIT) ovf = 1'b1;
          end else if (p1 >= p2) begin
            rmag = p1 - p2;
            rneg = aneg;
          end else begin
            rmag = p2 - p1;
            rneg = tneg;
          end
          if (!ovf) begin
            if (rmag == 0) rneg = 1'b0;
            g = gcd64(rmag, l);
            if (g == 0) g = 1;
            rmag = rmag / g;
            l = l / g;
            acc_num = rneg ? -rmag : rmag;
            acc_den = l;
          end
        end
      end
    end
    aneg = acc_num[63];
    amag = aneg ? -acc_num : acc_num;
    ad = (acc_den != 0) ? acc_den : 64'd1;
    s.num = acc_num;
    s.den = ad[62:0];
    s.neg = aneg;
    s.whole = 63'(amag / ad);
    s.rem = 63'(amag % ad);
    s.ovf = ovf;
    return s;
  endfunction

  function automatic term_t rand_term(int kind);
    term_t t;
    t.clr = ($urandom_range(0, 9) == 0);
    case (kind)
      0: begin
        t.num = $signed(32'($urandom_range(0, 40)) - 32'sd20);
        t.den = 31'($urandom_range(1, 30));
      end
      1: begin
        t.num = $urandom;
        t.den = 31'($urandom_range(1, 1000));
      end
      2: begin
        t.num = $urandom;
        t.den = 31'($urandom);
        if ($urandom_range(0, 30) == 0) t.den = '0;
      end
      default: begin
        t.num = $signed(32'($urandom_range(0, 2000)) - 32'sd1000);
        t.den = 31'($urandom_range(1, 200)) * 31'($urandom_range(1, 200));
      end
    endcase
    return t;
  endfunction

  task automatic push_term(logic signed [31:0] n, logic [30:0] d, logic c);
    pending_terms.push_back('{num: n, den: d, clr: c});
  endtask

  task automatic wait_drained();
    while (pending_terms.size() != 0 || in_valid || expected_sums.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_terms.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          term_t t;
          t = pending_terms.pop_front();
          in_valid <= 1'b1;
          in_term_numerator <= t.num;
          in_term_denominator <= t.den;
          in_start_new_sum <= t.clr;
          expected_sums.push_back(add_term(t));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_count > 0) begin
        hold_count <= hold_count - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        sum_t e;
        e = expected_sums.pop_front();
        if (out_sum_numerator !== e.num) begin
          $error("sum_numerator exp %0d got %0d", e.num, out_sum_numerator);
          errors++;
        end
        if (out_sum_denominator !== e.den) begin
          $error("sum_denominator exp %0d got %0d", e.den, out_sum_denominator);
          errors++;
        end
        if (out_is_negative !== e.neg) begin
          $error("is_negative exp %0d got %0d", e.neg, out_is_negative);
          errors++;
        end
        if (out_whole_part !== e.whole) begin
          $error("whole_part exp %0d got %0d", e.whole, out_whole_part);
          errors++;
        end
        if (out_remainder_numerator !== e.rem) begin
          $error("remainder_numerator exp %0d got %0d", e.rem, out_remainder_numerator);
          errors++;
        end
        if (out_overflow !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, signs, zero sum, zero denominator, overflow
    push_term(32'sd1, 31'd2, 1'b0);
    push_term(32'sd1, 31'd3, 1'b0);
    push_term(-32'sd5, 31'd6, 1'b0);
    push_term(32'sd0, 31'd1, 1'b1);
    push_term(-32'sd7, 31'd3, 1'b0);
    push_term(32'h7FFF_FFFF, 31'd1, 1'b1);
    push_term(32'sh8000_0000, 31'd1, 1'b0);
    push_term(32'sh8000_0000, 31'd1, 1'b1);
    push_term(32'sd3, 31'd0, 1'b0);
    push_term(32'sd3, 31'd0, 1'b1);
    push_term(32'sd1, 31'h7FFF_FFFF, 1'b1);
    push_term(32'sd1, 31'h7FFF_FFFE, 1'b0);
    push_term(32'sd1, 31'h7FFF_FFFD, 1'b0);
    push_term(32'sd1, 31'h7FFF_FFFC, 1'b0);
    push_term(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    push_term(32'h7FFF_FFFF, 31'h5555_5555, 1'b0);
    push_term(-32'sd1, 31'h7FFF_FFFF, 1'b1);
    push_term(32'sd1, 31'h7FFF_FFFF, 1'b0);
    push_term(-32'sd9, 31'd4, 1'b1);
    push_term(32'sd5, 31'd2, 1'b0);
    for (int i = 0; i < 5; i++) push_term(32'h7FFF_FFFF, 31'd1, 1'b0);
    wait_drained();

    // long receiver hold while terms keep coming
    hold_count = LONG_HOLD;
    for (int i = 0; i < 20; i++) push_term(rand_term(0).num, rand_term(0).den, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 78 : 34) : 0;
      recv_stall_pct = (ph == 2) ? 78 : ((ph == 3) ? 34 : 0);
      for (int i = 0; i < 420; i++) pending_terms.push_back(rand_term($urandom_range(0, 3)));
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4000) @(posedge clk);
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rsa_pkg.sv
design/rsa_alu.sv
design/rational_sum_accumulator.sv
design/rsa_checker.sv
verif/tb.sv
